// ===== rtl/mksd_pkg.sv =====
package mksd_pkg;

    localparam int NUM_COLS           = 3;
    localparam int HISTORY_BITS_DEF   = 8;
    localparam int SAMPLE_DIVISOR_DEF = 4;
    localparam int NUM_KEYS           = 9;

    localparam logic [2:0] ROW_RESET  = 3'b110;
    localparam logic [7:0] HOLD_RESET = 8'd9;
    localparam logic [7:0] CODE_NONE  = 8'hFF;

    localparam logic [7:0] KEY_CODES [NUM_KEYS] = '{
        8'hBB, 8'hDB, 8'hEB, 8'hBD, 8'hDD, 8'hED, 8'hBE, 8'hDE, 8'hEE
    };

    typedef enum logic {
        MODE_TICK = 1'b0,
        MODE_READ = 1'b1
    } t_mode;

    typedef struct packed {
        logic tick;
        logic match;
        logic pin;
    } t_lane_in;

    typedef struct packed {
        logic [2:0] row_drive;
        logic [7:0] scan_code;
        logic [3:0] key_number;
        logic       key_valid;
    } t_result;

    function automatic logic [3:0] decode_key(input logic [7:0] code);
        logic [3:0] key;
        key = 4'd0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            if (KEY_CODES[k] == code) begin
                key = 4'(k + 1);
            end
        end
        return key;
    endfunction

endpackage

// ===== rtl/mksd_lane.sv =====
module mksd_lane
    import mksd_pkg::*;
#(
    parameter int HISTORY_BITS   = HISTORY_BITS_DEF,
    parameter int SAMPLE_DIVISOR = SAMPLE_DIVISOR_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_lane_in i_lane,
    output logic     o_latch
);

    localparam int CNT_W = (SAMPLE_DIVISOR > 1) ? $clog2(SAMPLE_DIVISOR) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLE_DIVISOR - 1);

    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic [HISTORY_BITS-1:0] r_hist, n_hist;
    logic                    r_down, n_down;

    always_comb begin
        if (i_lane.match || r_cnt == CNT_LAST) begin
            n_cnt = '0;
        end else begin
            n_cnt = r_cnt + CNT_W'(1);
        end

        if (i_lane.match || n_cnt == '0) begin
            n_hist = {r_hist[HISTORY_BITS-2:0], i_lane.pin};
        end else begin
            n_hist = r_hist;
        end

        o_latch = (n_hist == '0) && !r_down;

        if (o_latch) begin
            n_down = 1'b1;
        end else if ((&n_hist) && r_down) begin
            n_down = 1'b0;
        end else begin
            n_down = r_down;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_hist <= '0;
            r_down <= 1'b0;
        end else if (i_lane.tick) begin
            r_cnt  <= n_cnt;
            r_hist <= n_hist;
            r_down <= n_down;
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_LAST)
        else $error("mismatch counter out of range");

    a_latch_sets_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_lane.tick && o_latch) |=> r_down)
        else $error("latch did not mark column down");

    a_no_tick_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_lane.tick |=> $stable(r_hist) && $stable(r_down))
        else $error("lane state moved without a tick");
`endif

endmodule

// ===== rtl/mksd_skid.sv =====
module mksd_skid
    import mksd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;

    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (i_ready || !r_out_valid) begin
            r_out_valid  <= r_skid_valid || i_push;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ready || !r_out_valid) begin
            r_out <= r_skid_valid ? r_skid : i_data;
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

`ifndef SYNTHESIS
    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage full while output empty");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_ready) |=> r_skid_valid && $stable(r_skid))
        else $error("skid stage lost its transaction");

    a_drain_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_ready) |=> (r_out == $past(r_skid)) && !r_skid_valid)
        else $error("skid stage drained out of order");
`endif

endmodule

// ===== rtl/matrix_keypad_scan_debounce.sv =====
// 3x3 key matrix scanner with per-column debounce
// input channel (i_in_valid / o_in_ready): one transaction per scan tick
// (i_mode tick) carrying the sampled column and row pins, or a read
// (i_mode read) that decodes the latched key code and clears it
// output channel (o_out_valid / i_out_ready): exactly one result transaction
// per input transaction, in order: row drive, scan code, key number, key valid
// each accepted result is registered in the output register, or in the skid
// stage while the receiver stalls; throughput is one transaction per cycle
// while o_in_ready is high, set by the update of the three column lanes
// and the code register; the output register is backed by a one-entry skid
// stage, so one more transaction is taken while a result waits; o_in_ready
// is low while the skid stage holds one, filled only when the receiver stalls
// i_cfg_we writes the row hold count from i_cfg_wdata in the same cycle
// reset (synchronous, active low) gives row drive 110, hold count 9,
// cleared histories and down flags, scan code 0xFF and an empty output
module matrix_keypad_scan_debounce
    import mksd_pkg::*;
#(
    parameter int HISTORY_BITS   = HISTORY_BITS_DEF,
    parameter int SAMPLE_DIVISOR = SAMPLE_DIVISOR_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_mode,
    input  logic [2:0] i_column_levels,
    input  logic [2:0] i_row_levels,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [2:0] o_row_drive,
    output logic [7:0] o_scan_code,
    output logic [3:0] o_key_number,
    output logic       o_key_valid
);

    logic [7:0] r_hold;
    logic [7:0] r_tick, n_tick;
    logic [2:0] r_row, n_row;
    logic [7:0] r_code, n_code;

    logic                accept;
    logic                is_tick;
    logic [NUM_COLS-1:0] latch;
    t_result             result;
    t_result             out_data;

    assign accept  = i_in_valid && o_in_ready;
    assign is_tick = accept && (t_mode'(i_mode) == MODE_TICK);

    for (genvar c = 0; c < NUM_COLS; c++) begin : g_lane
        localparam logic [2:0] DOWN_LEVEL = ~(3'b001 << c);
        t_lane_in lane_in;

        always_comb begin
            lane_in.tick  = is_tick;
            lane_in.match = (i_column_levels == DOWN_LEVEL);
            lane_in.pin   = i_column_levels[c];
        end

        mksd_lane #(
            .HISTORY_BITS   (HISTORY_BITS),
            .SAMPLE_DIVISOR (SAMPLE_DIVISOR)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_lane  (lane_in),
            .o_latch (latch[c])
        );
    end

    always_comb begin
        if (r_tick >= r_hold) begin
            n_tick = '0;
            n_row  = {r_row[1:0], r_row[2]};
        end else begin
            n_tick = r_tick + 8'd1;
            n_row  = r_row;
        end

        result.key_number = 4'd0;
        result.key_valid  = 1'b0;
        unique case (t_mode'(i_mode))
            MODE_TICK: begin
                n_code = (|latch) ? {1'b1, i_column_levels, 1'b1, i_row_levels} : r_code;
                result.row_drive = n_row;
                result.scan_code = n_code;
            end
            MODE_READ: begin
                n_code = CODE_NONE;
                result.row_drive  = r_row;
                result.scan_code  = r_code;
                result.key_number = decode_key(r_code);
                result.key_valid  = (result.key_number != 4'd0);
            end
            default: begin
                n_code           = r_code;
                result.row_drive = r_row;
                result.scan_code = r_code;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= HOLD_RESET;
        end else if (i_cfg_we) begin
            r_hold <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick <= '0;
            r_row  <= ROW_RESET;
            r_code <= CODE_NONE;
        end else if (accept) begin
            if (is_tick) begin
                r_tick <= n_tick;
                r_row  <= n_row;
            end
            r_code <= n_code;
        end
    end

    mksd_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (result),
        .o_ready (o_in_ready),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (out_data)
    );

    assign o_row_drive  = out_data.row_drive;
    assign o_scan_code  = out_data.scan_code;
    assign o_key_number = out_data.key_number;
    assign o_key_valid  = out_data.key_valid;

`ifndef SYNTHESIS
    a_row_one_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_row) == 2)
        else $error("row drive lost its single low bit");

    a_read_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && t_mode'(i_mode) == MODE_READ) |=> r_code == CODE_NONE)
        else $error("read transaction did not clear the code");

    a_stall_has_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no result pending");

    a_tick_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (is_tick && $stable(r_hold)) |=> (r_tick <= r_hold) || (r_tick == $past(r_tick) + 8'd1))
        else $error("tick counter ran past the hold count");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
    import mksd_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 10;
    localparam int ITEM_TARGET  = 550;

    // nibble patterns of a one-low line in the scan code
    localparam logic [3:0] LINE_ONE_LOW   = 4'hB;
    localparam logic [3:0] LINE_TWO_LOW   = 4'hD;
    localparam logic [3:0] LINE_THREE_LOW = 4'hE;

    localparam logic [2:0] ALL_HIGH = 3'b111;

    logic       i_clk           = 1'b0;
    logic       i_rst_n         = 1'b0;
    logic       i_cfg_we        = 1'b0;
    logic [7:0] i_cfg_wdata     = 8'd0;
    logic       i_in_valid      = 1'b0;
    logic       o_in_ready;
    logic       i_mode          = MODE_TICK;
    logic [2:0] i_column_levels = ALL_HIGH;
    logic [2:0] i_row_levels    = ALL_HIGH;
    logic       o_out_valid;
    logic       i_out_ready     = 1'b1;
    logic [2:0] o_row_drive;
    logic [7:0] o_scan_code;
    logic [3:0] o_key_number;
    logic       o_key_valid;

    matrix_keypad_scan_debounce i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_mode          (i_mode),
        .i_column_levels (i_column_levels),
        .i_row_levels    (i_row_levels),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_row_drive     (o_row_drive),
        .o_scan_code     (o_scan_code),
        .o_key_number    (o_key_number),
        .o_key_valid     (o_key_valid)
    );

    // scanner state as the checker sees it
    logic [7:0]                  hold_ticks;
    logic [7:0]                  tick_count;
    logic [2:0]                  row_pattern;
    logic [7:0]                  latched_code;
    logic [1:0]                  miss_count  [NUM_COLS];
    logic [HISTORY_BITS_DEF-1:0] col_history [NUM_COLS];
    logic                        key_down    [NUM_COLS];

    t_result     pending_results [$];
    int unsigned mismatch_count = 0;
    int unsigned items_sent     = 0;
    int unsigned cycle_count    = 0;
    bit          no_idle        = 1'b0;
    logic [3:0]  stall_left     = 4'd0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    task automatic reset_scanner_state();
        hold_ticks   = HOLD_RESET;
        tick_count   = 8'd0;
        row_pattern  = ROW_RESET;
        latched_code = CODE_NONE;
        for (int c = 0; c < NUM_COLS; c++) begin
            miss_count[c]  = 2'd0;
            col_history[c] = '0;
            key_down[c]    = 1'b0;
        end
    endtask

    function automatic int line_position(input logic [3:0] nibble);
        case (nibble)
            LINE_ONE_LOW:   return 0;
            LINE_TWO_LOW:   return 1;
            LINE_THREE_LOW: return 2;
            default:        return -1;
        endcase
    endfunction

    function automatic logic [3:0] key_from_code(input logic [7:0] code);
        int col_pos;
        int row_pos;
        col_pos = line_position(code[7:4]);
        row_pos = line_position(code[3:0]);
        if (col_pos < 0 || row_pos < 0) begin
            return 4'd0;
        end
        return 4'(3 * row_pos + col_pos + 1);
    endfunction

    task automatic predict_scan(input t_mode mode, input logic [2:0] cols,
                                input logic [2:0] rows, output t_result res);
        logic hit;
        res = '0;
        if (mode == MODE_TICK) begin
            if (tick_count >= hold_ticks) begin
                row_pattern = {row_pattern[1:0], row_pattern[2]};
                tick_count  = 8'd0;
            end else begin
                tick_count = tick_count + 8'd1;
            end
            for (int c = 0; c < NUM_COLS; c++) begin
                hit = (cols == (ALL_HIGH ^ (3'b001 << c)));
                miss_count[c] = hit ? 2'd0 : 2'((miss_count[c] + 1) % SAMPLE_DIVISOR_DEF);
                if (hit || miss_count[c] == 2'd0) begin
                    col_history[c] = {col_history[c][HISTORY_BITS_DEF-2:0], cols[c]};
                end
                if (col_history[c] == '0 && !key_down[c]) begin
                    latched_code = {1'b1, cols, 1'b1, rows};
                    key_down[c]  = 1'b1;
                end else if ((&col_history[c]) && key_down[c]) begin
                    key_down[c] = 1'b0;
                end
            end
            res.scan_code = latched_code;
        end else begin
            res.scan_code  = latched_code;
            res.key_number = key_from_code(latched_code);
            res.key_valid  = (res.key_number != 4'd0);
            latched_code   = CODE_NONE;
        end
        res.row_drive = row_pattern;
    endtask

    task automatic send_item(input t_mode mode, input logic [2:0] cols, input logic [2:0] rows);
        int unsigned gap;
        t_result     res;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_mode          <= mode;
        i_column_levels <= cols;
        i_row_levels    <= rows;
        do @(posedge i_clk); while (!o_in_ready);
        predict_scan(mode, cols, rows, res);
        pending_results.push_back(res);
        items_sent++;
    endtask

    task automatic tick(input logic [2:0] cols, input logic [2:0] rows);
        send_item(MODE_TICK, cols, rows);
    endtask

    task automatic read_key();
        send_item(MODE_READ, 3'($urandom), 3'($urandom));
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_hold_ticks(input logic [7:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        hold_ticks = value;
    endtask

    task automatic check_result();
        t_result want;
        t_result got;
        got = {o_row_drive, o_scan_code, o_key_number, o_key_valid};
        if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
                $display("unexpected transaction: row_drive %b scan_code %h key %0d valid %b",
                         got.row_drive, got.scan_code, got.key_number, got.key_valid);
            end
            return;
        end
        want = pending_results.pop_front();
        if (got.row_drive != want.row_drive || got.scan_code != want.scan_code ||
            got.key_number != want.key_number || got.key_valid != want.key_valid) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
                $display("mismatch exp/act: row_drive %b/%b scan_code %h/%h key %0d/%0d valid %b/%b",
                         want.row_drive, got.row_drive, want.scan_code, got.scan_code,
                         want.key_number, got.key_number, want.key_valid, got.key_valid);
            end
        end
    endtask

    always @(posedge i_clk) begin : result_sink
        int unsigned stall;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            check_result();
            stall = no_idle ? 0 : $urandom_range(0, 15);
            stall_left  <= 4'(stall);
            i_out_ready <= (stall == 0);
        end else if (!i_out_ready) begin
            if (stall_left <= 4'd1) begin
                i_out_ready <= 1'b1;
            end
            stall_left <= stall_left - 4'd1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic test_directed();
        read_key();
        tick(3'b000, 3'b000);
        tick(ALL_HIGH, ALL_HIGH);
        read_key();
        read_key();
        send_item(MODE_READ, 3'b000, 3'b000);
        send_item(MODE_READ, ALL_HIGH, ALL_HIGH);
        for (int c = 0; c < NUM_COLS; c++) begin
            for (int r = 0; r < 3; r++) begin
                tick(ALL_HIGH ^ (3'b001 << c), ALL_HIGH ^ (3'b001 << r));
            end
        end
        tick(3'b101, 3'b010);
        tick(3'b010, 3'b101);
        read_key();
        tick(3'b100, 3'b001);
        read_key();
    endtask

    task automatic test_hold_register();
        wait_drained();
        write_hold_ticks(8'd0);
        repeat (12) tick(ALL_HIGH, 3'($urandom));
        wait_drained();
        write_hold_ticks(8'd255);
        repeat (20) tick(3'($urandom), 3'($urandom));
        // counter now above the new hold value, next tick rotates
        wait_drained();
        write_hold_ticks(8'd3);
        repeat (8) tick(ALL_HIGH, 3'($urandom));
        wait_drained();
        write_hold_ticks(8'd1);
        repeat (6) tick(ALL_HIGH, 3'($urandom));
        wait_drained();
        write_hold_ticks(HOLD_RESET);
    endtask

    task automatic test_keystrokes(input int unsigned target);
        int unsigned strokes;
        int unsigned press_len;
        int unsigned release_len;
        int          col;
        logic [2:0]  press_cols;
        logic [2:0]  press_rows;
        strokes = 0;
        while (items_sent < target) begin
            if (strokes % 4 == 3) begin
                wait_drained();
                write_hold_ticks(($urandom_range(0, 4) == 0) ? 8'($urandom)
                                                             : 8'($urandom_range(0, 15)));
                no_idle = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 9) == 0) begin
                wait_drained();
            end
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(5, 15)) begin
                    send_item(t_mode'($urandom_range(0, 1)), 3'($urandom), 3'($urandom));
                end
            end
            col        = $urandom_range(0, 2);
            press_cols = ALL_HIGH ^ (3'b001 << col);
            press_rows = ($urandom_range(0, 3) != 0) ? ALL_HIGH ^ (3'b001 << $urandom_range(0, 2))
                                                     : 3'($urandom);
            press_len   = $urandom_range(3, 12);
            release_len = $urandom_range(10, 40);
            for (int i = 0; i < press_len; i++) begin
                if ($urandom_range(0, 9) == 0) begin
                    tick(3'($urandom), 3'($urandom));
                end else begin
                    tick(press_cols, press_rows);
                end
                if ($urandom_range(0, 19) == 0) begin
                    read_key();
                end
            end
            for (int i = 0; i < release_len; i++) begin
                if ($urandom_range(0, 9) == 0) begin
                    tick(3'($urandom), 3'($urandom));
                end else begin
                    tick(ALL_HIGH, press_rows);
                end
            end
            if ($urandom_range(0, 4) != 0) begin
                read_key();
            end
            strokes++;
        end
        no_idle = 1'b0;
    endtask

    initial begin
        reset_scanner_state();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_hold_register();
        test_keystrokes(ITEM_TARGET);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/mksd_pkg.sv
rtl/mksd_lane.sv
rtl/mksd_skid.sv
rtl/matrix_keypad_scan_debounce.sv
tb/sv/testbench.sv
